/* src/smm_pkg.sv */
package smm_pkg;

  localparam int DATA_W     = 32;
  localparam int FRAC_W     = 16;
  localparam int OUT_IDX_W  = 2;
  localparam int SIZE_DEF   = 3;

  typedef enum logic [1:0] {
    S_LOAD,
    S_RUN,
    S_DRAIN
  } seq_state_t;

  typedef struct packed {
    logic                 valid;
    logic                 first;
    logic                 last_k;
    logic                 last_run;
    logic [OUT_IDX_W-1:0] row;
    logic [OUT_IDX_W-1:0] col;
  } mac_tag_t;

endpackage

/* src/smm_dot.sv */
module smm_dot
  import smm_pkg::*;
#(
  parameter int SIZE = SIZE_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic signed [DATA_W-1:0] a_data,
  input  logic signed [DATA_W-1:0] b_data,
  input  mac_tag_t                 tag_in,
  output logic signed [DATA_W-1:0] product_element,
  output logic [OUT_IDX_W-1:0]     row_index,
  output logic [OUT_IDX_W-1:0]     column_index,
  output logic                     last_of_run,
  output logic                     strobe
);

  localparam int ACC_W = 2 * DATA_W + $clog2(SIZE) + 1;
  localparam logic signed [ACC_W-1:0] SAT_HI =
    {{(ACC_W - DATA_W + 1){1'b0}}, {(DATA_W - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO =
    {{(ACC_W - DATA_W + 1){1'b1}}, {(DATA_W - 1){1'b0}}};
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_W - 1);

  logic signed [2*DATA_W-1:0] prod;
  mac_tag_t                   tag_p;
  logic signed [ACC_W-1:0]    acc;
  mac_tag_t                   tag_a;
  logic signed [ACC_W-1:0]    rounded;
  logic signed [ACC_W-1:0]    shifted;
  logic signed [DATA_W-1:0]   sat_value;

  // multiply stage
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_p.valid <= 1'b0;
    end else begin
      tag_p <= tag_in;
    end
    prod <= a_data * b_data;
  end

  // accumulate stage
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_a.valid <= 1'b0;
    end else begin
      tag_a <= tag_p;
    end
    if (tag_p.valid) begin
      if (tag_p.first) begin
        acc <= ACC_W'(prod);
      end else begin
        acc <= acc + ACC_W'(prod);
      end
    end
  end

  // round half up, then saturate
  always_comb begin
    rounded = acc + HALF;
    shifted = rounded >>> FRAC_W;
    if (shifted > SAT_HI) begin
      sat_value = SAT_HI[DATA_W-1:0];
    end else if (shifted < SAT_LO) begin
      sat_value = SAT_LO[DATA_W-1:0];
    end else begin
      sat_value = shifted[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= tag_a.valid && tag_a.last_k;
    end
    if (tag_a.valid && tag_a.last_k) begin
      product_element <= sat_value;
      row_index       <= tag_a.row;
      column_index    <= tag_a.col;
      last_of_run     <= tag_a.last_run;
    end
  end

endmodule

/* src/square_matrix_multiply.sv */
// channel  | ports                                                | handshake
// ---------+------------------------------------------------------+---------------------
// in       | a_element, b_element                                 | start && !busy
// out      | product_element, row_index, column_index, last_of_run| strobe, one cycle
//
// one element pair is loaded per cycle while start is high and busy is low.
// the last pair of a matrix raises busy; the product then takes SIZE*SIZE*SIZE
// multiply-accumulates, one per cycle, set by the single read port of each store,
// through the store read, multiply, accumulate and output registers; busy falls
// after the final item. results come out in row-major order; the receiver cannot stall.
// synchronous reset clears the sequencer and the load count, not the stores.
module square_matrix_multiply
  import smm_pkg::*;
#(
  parameter int SIZE = SIZE_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [DATA_W-1:0] a_element,
  input  logic signed [DATA_W-1:0] b_element,
  output logic                     strobe,
  output logic signed [DATA_W-1:0] product_element,
  output logic [OUT_IDX_W-1:0]     row_index,
  output logic [OUT_IDX_W-1:0]     column_index,
  output logic                     last_of_run
);

  localparam int NELEM  = SIZE * SIZE;
  localparam int ADDR_W = $clog2(NELEM);
  localparam int IDX_W  = $clog2(SIZE);

  logic signed [DATA_W-1:0] left_store  [NELEM];
  logic signed [DATA_W-1:0] right_store [NELEM];

  seq_state_t               state;
  seq_state_t               state_next;
  logic [ADDR_W-1:0]        load_count;
  logic [IDX_W-1:0]         r;
  logic [IDX_W-1:0]         c;
  logic [IDX_W-1:0]         k;
  logic [ADDR_W-1:0]        row_base;
  logic [ADDR_W-1:0]        b_addr;
  logic [ADDR_W-1:0]        a_addr;
  logic                     accept;
  logic                     load_done;
  logic                     issue;
  logic                     k_end;
  logic                     c_end;
  logic                     r_end;
  logic signed [DATA_W-1:0] a_data;
  logic signed [DATA_W-1:0] b_data;
  mac_tag_t                 tag_rd;
  logic                     run_done;

  assign busy      = (state != S_LOAD);
  assign accept    = start && !busy;
  assign load_done = accept && (load_count == ADDR_W'(NELEM - 1));
  assign issue     = (state == S_RUN);
  assign k_end     = (k == IDX_W'(SIZE - 1));
  assign c_end     = (c == IDX_W'(SIZE - 1));
  assign r_end     = (r == IDX_W'(SIZE - 1));
  assign a_addr    = row_base + ADDR_W'(k);
  assign run_done  = strobe && last_of_run;

  always_ff @(posedge clk) begin
    if (accept) begin
      left_store[load_count] <= a_element;
    end
    if (issue) begin
      a_data <= left_store[a_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      right_store[load_count] <= b_element;
    end
    if (issue) begin
      b_data <= right_store[b_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_LOAD: begin
        if (load_done) begin
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        if (k_end && c_end && r_end) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (run_done) begin
          state_next = S_LOAD;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
      r          <= '0;
      c          <= '0;
      k          <= '0;
      row_base   <= '0;
      b_addr     <= '0;
    end else begin
      if (accept) begin
        load_count <= load_done ? '0 : load_count + ADDR_W'(1);
      end
      if (load_done) begin
        r        <= '0;
        c        <= '0;
        k        <= '0;
        row_base <= '0;
        b_addr   <= '0;
      end else if (issue) begin
        if (k_end) begin
          k <= '0;
          if (c_end) begin
            c        <= '0;
            b_addr   <= '0;
            r        <= r + IDX_W'(1);
            row_base <= row_base + ADDR_W'(SIZE);
          end else begin
            c      <= c + IDX_W'(1);
            b_addr <= ADDR_W'(c) + ADDR_W'(1);
          end
        end else begin
          k      <= k + IDX_W'(1);
          b_addr <= b_addr + ADDR_W'(SIZE);
        end
      end
    end
  end

  // tag travels with the read data
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_rd.valid <= 1'b0;
    end else begin
      tag_rd.valid <= issue;
    end
    tag_rd.first    <= (k == '0);
    tag_rd.last_k   <= k_end;
    tag_rd.last_run <= r_end && c_end;
    tag_rd.row      <= OUT_IDX_W'(r);
    tag_rd.col      <= OUT_IDX_W'(c);
  end

  smm_dot #(
    .SIZE (SIZE)
  ) u_dot (
    .clk             (clk),
    .rst             (rst),
    .a_data          (a_data),
    .b_data          (b_data),
    .tag_in          (tag_rd),
    .product_element (product_element),
    .row_index       (row_index),
    .column_index    (column_index),
    .last_of_run     (last_of_run),
    .strobe          (strobe)
  );

endmodule

/* tb/sv/square_matrix_multiply_tb.sv */
module square_matrix_multiply_tb;
  import smm_pkg::*;

  localparam int N = SIZE_DEF;
  localparam int ELEMS = N * N;
  localparam int TAIL_CYCLES = N * N * N + 8;
  localparam int CYCLE_LIMIT = 100000;
  localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFFFFFF;
  localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh80000000;
  localparam logic signed [DATA_W-1:0] Q_HALF_LSB = 32'sh00008000;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic [OUT_IDX_W-1:0]     row;
    logic [OUT_IDX_W-1:0]     col;
    logic                     last;
  } product_entry_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic                     busy;
  logic signed [DATA_W-1:0] a_element = '0;
  logic signed [DATA_W-1:0] b_element = '0;
  logic                     strobe;
  logic signed [DATA_W-1:0] product_element;
  logic [OUT_IDX_W-1:0]     row_index;
  logic [OUT_IDX_W-1:0]     column_index;
  logic                     last_of_run;

  logic signed [DATA_W-1:0] left_copy [ELEMS];
  logic signed [DATA_W-1:0] right_copy [ELEMS];
  int                       pairs_loaded = 0;
  product_entry_t           pending_products [$];
  product_entry_t           oldest_product;
  int                       error_count = 0;
  int                       cycle_count = 0;
  bit                       sender_idles = 1'b1;

  square_matrix_multiply #(.SIZE(N)) dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .a_element       (a_element),
    .b_element       (b_element),
    .strobe          (strobe),
    .product_element (product_element),
    .row_index       (row_index),
    .column_index    (column_index),
    .last_of_run     (last_of_run)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // rounded, saturated dot product of row r of A with column c of B
  function automatic logic signed [DATA_W-1:0] dot_entry(input int r, input int c);
    logic signed [71:0] acc;
    logic signed [71:0] lhs;
    logic signed [71:0] rhs;
    logic signed [71:0] rounded;
    acc = '0;
    for (int k = 0; k < N; k++) begin
      lhs = left_copy[r * N + k];
      rhs = right_copy[k * N + c];
      acc = acc + lhs * rhs;
    end
    rounded = (acc + 72'sd32768) >>> FRAC_W;
    if (rounded > 72'sd2147483647) return Q_MAX;
    if (rounded < -72'sd2147483648) return Q_MIN;
    return rounded[DATA_W-1:0];
  endfunction

  task automatic load_pair(input logic signed [DATA_W-1:0] a, input logic signed [DATA_W-1:0] b);
    product_entry_t entry;
    left_copy[pairs_loaded] = a;
    right_copy[pairs_loaded] = b;
    pairs_loaded++;
    if (pairs_loaded == ELEMS) begin
      pairs_loaded = 0;
      for (int r = 0; r < N; r++) begin
        for (int c = 0; c < N; c++) begin
          entry.value = dot_entry(r, c);
          entry.row = OUT_IDX_W'(r);
          entry.col = OUT_IDX_W'(c);
          entry.last = (r == N - 1) && (c == N - 1);
          pending_products.push_back(entry);
        end
      end
    end
  endtask

  task automatic send_pair(input logic signed [DATA_W-1:0] a, input logic signed [DATA_W-1:0] b);
    int gap;
    gap = sender_idles ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    a_element <= a;
    b_element <= b;
    do @(posedge clk); while (busy);
    load_pair(a, b);
  endtask

  task automatic wait_for_products();
    start <= 1'b0;
    while (pending_products.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_element();
    int v;
    case ($urandom_range(0, 6))
      0, 1, 2: return $urandom();
      3: begin
        v = $urandom_range(0, 524288);
        return v - 262144;
      end
      4: return $urandom_range(0, 1) ? Q_MAX : Q_MIN;
      5: return $urandom_range(0, 1) ? Q_HALF_LSB : -Q_HALF_LSB;
      default: begin
        v = $urandom_range(0, 6);
        return v - 3;
      end
    endcase
  endfunction

  task automatic send_random_matrices(input int count);
    for (int m = 0; m < count; m++) begin
      for (int i = 0; i < ELEMS; i++) send_pair(pick_element(), pick_element());
    end
  endtask

  task automatic test_saturation_extremes();
    logic signed [DATA_W-1:0] lhs [ELEMS];
    logic signed [DATA_W-1:0] rhs [ELEMS];
    lhs = '{Q_MAX, Q_MAX, Q_MAX, Q_MIN, 32'sd0, -32'sd1, 32'sd1, 32'sd0, 32'sd0};
    rhs = '{Q_MAX, Q_MIN, Q_HALF_LSB, Q_MAX, Q_MIN, Q_HALF_LSB, Q_MAX, Q_MIN, Q_HALF_LSB};
    for (int i = 0; i < ELEMS; i++) send_pair(lhs[i], rhs[i]);
  endtask

  task automatic test_rounding_ties();
    logic signed [DATA_W-1:0] rhs [ELEMS];
    rhs = '{Q_HALF_LSB, -Q_HALF_LSB, Q_HALF_LSB, Q_HALF_LSB, -Q_HALF_LSB, Q_HALF_LSB,
            Q_HALF_LSB, -Q_HALF_LSB, -Q_HALF_LSB};
    for (int i = 0; i < ELEMS; i++) send_pair(32'sd1, rhs[i]);
  endtask

  task automatic test_random_matrices();
    send_random_matrices(35);
  endtask

  task automatic test_back_to_back();
    sender_idles = 1'b0;
    send_random_matrices(4);
    sender_idles = 1'b1;
  endtask

  task automatic test_pause_until_drained();
    send_random_matrices(1);
    wait_for_products();
    send_random_matrices(1);
  endtask

  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (pending_products.size() == 0) begin
        $display("%0t: unexpected product expected none got %h [%0d][%0d] last %b", $time,
                 product_element, row_index, column_index, last_of_run);
        error_count++;
      end else begin
        oldest_product = pending_products.pop_front();
        if (product_element !== oldest_product.value) begin
          $display("%0t: product_element expected %h got %h", $time, oldest_product.value,
                   product_element);
          error_count++;
        end
        if (row_index !== oldest_product.row) begin
          $display("%0t: row_index expected %0d got %0d", $time, oldest_product.row, row_index);
          error_count++;
        end
        if (column_index !== oldest_product.col) begin
          $display("%0t: column_index expected %0d got %0d", $time, oldest_product.col,
                   column_index);
          error_count++;
        end
        if (last_of_run !== oldest_product.last) begin
          $display("%0t: last_of_run expected %b got %b", $time, oldest_product.last,
                   last_of_run);
          error_count++;
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_saturation_extremes();
    test_rounding_ties();
    test_random_matrices();
    test_back_to_back();
    test_pause_until_drained();
    wait_for_products();
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/smm_pkg.sv
src/smm_dot.sv
src/square_matrix_multiply.sv
tb/sv/square_matrix_multiply_tb.sv
